>>> hdl/sequenced_chunk_reassembler_core_macros.svh
// assertion macros for the sequenced chunk reassembler checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef SEQUENCED_CHUNK_REASSEMBLER_CORE_MACROS_SVH
`define SEQUENCED_CHUNK_REASSEMBLER_CORE_MACROS_SVH

// plain property, checked on every clock outside reset
`define SCR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("scr check failed");

// antecedent in one cycle, consequent in the next
`define SCR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scr check failed");

`endif

>>> hdl/scr_pkg.sv
// shared constants, codes and types of the sequenced chunk reassembler
// no dependencies; used by every module of the block but scr_ram
package scr_pkg;

    localparam int HEADER_BYTES   = 6;
    localparam int CHUNK_DATA_MAX = 128;
    localparam int FRAME_MAX      = 134;
    localparam int PAYLOAD_MAX    = 4096;
    localparam int MAX_CHUNKS     = PAYLOAD_MAX / CHUNK_DATA_MAX;

    localparam int ADDR_W      = $clog2(PAYLOAD_MAX);
    localparam int CHUNK_SEL_W = $clog2(MAX_CHUNKS);
    localparam int CNT_W       = $clog2(MAX_CHUNKS + 1);
    localparam int POS_W       = $clog2(FRAME_MAX + 2);
    localparam int OFF_W       = 8;

    // command queue between front and back, power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // input function codes
    localparam logic [1:0] FUNC_FRAME = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef enum logic [3:0] {
        ST_PENDING  = 4'd0,
        ST_COMPLETE = 4'd1,
        ST_IGNORED  = 4'd2,
        ST_SHORT    = 4'd3,
        ST_LONG     = 4'd4,
        ST_VERSION  = 4'd5,
        ST_ZERO     = 4'd6,
        ST_LARGE    = 4'd7,
        ST_LENGTH   = 4'd8,
        ST_RANGE    = 4'd9,
        ST_TOTAL    = 4'd10,
        ST_DUP      = 4'd11
    } t_status;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_END,
        OP_READ,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [7:0]        data;
        logic              wr_ok;
        logic [ADDR_W-1:0] wr_addr;
        logic [POS_W-1:0]  size;
        logic [7:0]        ver;
        logic [15:0]       seq;
        logic [15:0]       total;
        logic [7:0]        len;
    } t_cmd;

    typedef struct packed {
        t_status    status;
        logic [7:0] pbyte;
        logic       pvalid;
        logic       plast;
    } t_result;

endpackage

>>> hdl/scr_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module scr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hdl/scr_front.sv
// front end: accepts items, tracks frame position and header, builds commands
// depends on scr_pkg
module scr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [1:0]    i_func,
    input  logic [7:0]    i_data,
    input  logic          i_last,
    input  logic          i_q_full,
    output logic          o_ready,
    output logic          o_push,
    output scr_pkg::t_cmd o_cmd
);

    logic [scr_pkg::POS_W-1:0] r_pos, n_pos;
    logic [39:0]               r_hdr, n_hdr;
    logic [7:0]                r_ver, n_ver;

    logic                      accept;
    logic [scr_pkg::POS_W-1:0] data_idx;
    logic [15:0]               hdr_seq;
    logic [scr_pkg::POS_W-1:0] f_pos;
    logic [39:0]               f_hdr;
    logic [7:0]                f_ver;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;

    always_comb begin
        data_idx = r_pos - scr_pkg::POS_W'(scr_pkg::HEADER_BYTES);
        hdr_seq  = r_hdr[39:24];
        f_pos    = r_pos;
        f_hdr    = r_hdr;
        f_ver    = r_ver;
        // header bytes update the captured fields
        if (r_pos == '0) begin
            f_ver = i_data;
        end else if (r_pos < scr_pkg::POS_W'(scr_pkg::HEADER_BYTES)) begin
            f_hdr = {r_hdr[31:0], i_data};
        end
        // size saturates one past the longest legal frame
        if (r_pos <= scr_pkg::POS_W'(scr_pkg::FRAME_MAX)) begin
            f_pos = r_pos + scr_pkg::POS_W'(1);
        end

        n_pos  = r_pos;
        n_hdr  = r_hdr;
        n_ver  = r_ver;
        o_push = 1'b0;

        o_cmd.op      = scr_pkg::OP_BYTE;
        o_cmd.data    = i_data;
        o_cmd.wr_ok   = (r_pos >= scr_pkg::POS_W'(scr_pkg::HEADER_BYTES)) &&
                        (data_idx < scr_pkg::POS_W'(scr_pkg::CHUNK_DATA_MAX)) &&
                        (hdr_seq < 16'(scr_pkg::MAX_CHUNKS));
        o_cmd.wr_addr = scr_pkg::ADDR_W'(
                        scr_pkg::ADDR_W'(hdr_seq[scr_pkg::CHUNK_SEL_W-1:0]) *
                        scr_pkg::ADDR_W'(scr_pkg::CHUNK_DATA_MAX) +
                        scr_pkg::ADDR_W'(data_idx));
        o_cmd.size    = f_pos;
        o_cmd.ver     = f_ver;
        o_cmd.seq     = f_hdr[39:24];
        o_cmd.total   = f_hdr[23:8];
        o_cmd.len     = f_hdr[7:0];

        if (accept) begin
            unique case (i_func)
                scr_pkg::FUNC_FRAME: begin
                    o_push   = 1'b1;
                    o_cmd.op = i_last ? scr_pkg::OP_END : scr_pkg::OP_BYTE;
                    if (i_last) begin
                        n_pos = '0;
                        n_hdr = '0;
                        n_ver = '0;
                    end else begin
                        n_pos = f_pos;
                        n_hdr = f_hdr;
                        n_ver = f_ver;
                    end
                end
                scr_pkg::FUNC_READ: begin
                    o_push   = 1'b1;
                    o_cmd.op = scr_pkg::OP_READ;
                end
                scr_pkg::FUNC_CLEAR: begin
                    o_push   = 1'b1;
                    o_cmd.op = scr_pkg::OP_CLEAR;
                    n_pos    = '0;
                    n_hdr    = '0;
                    n_ver    = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_hdr <= '0;
            r_ver <= '0;
        end else begin
            r_pos <= n_pos;
            r_hdr <= n_hdr;
            r_ver <= n_ver;
        end
    end

endmodule

>>> hdl/scr_queue.sv
// short command queue between front end and back end
// depends on scr_pkg
module scr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  scr_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output scr_pkg::t_cmd o_head,
    output logic          o_empty,
    output logic          o_full
);

    scr_pkg::t_cmd              r_mem [scr_pkg::QUEUE_DEPTH];
    logic [scr_pkg::QPTR_W-1:0] r_wptr;
    logic [scr_pkg::QPTR_W-1:0] r_rptr;
    logic [scr_pkg::QCNT_W-1:0] r_count;

    assign o_head  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == scr_pkg::QCNT_W'(scr_pkg::QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + scr_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + scr_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + scr_pkg::QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - scr_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

>>> hdl/scr_back.sv
// back end: frame checks, reassembly state, chunk store and payload readout
// depends on scr_pkg and scr_ram
module scr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_frame_version,
    input  logic             i_q_empty,
    input  scr_pkg::t_cmd    i_q_head,
    output logic             o_q_pop,
    input  logic             i_m_ready,
    output logic             o_m_valid,
    output scr_pkg::t_result o_m_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SKIP_A,
        S_FETCH,
        S_SKIP_B
    } t_state;

    t_state                          r_state, n_state;
    logic [scr_pkg::CNT_W-1:0]       r_exp_total, n_exp_total;
    logic [scr_pkg::CNT_W-1:0]       r_rcv, n_rcv;
    logic [scr_pkg::MAX_CHUNKS-1:0]  r_seen, n_seen;
    logic [7:0]                      r_len [scr_pkg::MAX_CHUNKS];
    logic [7:0]                      n_len [scr_pkg::MAX_CHUNKS];
    scr_pkg::t_status                r_sticky, n_sticky;
    logic [scr_pkg::CNT_W-1:0]       r_rd_chunk, n_rd_chunk;
    logic [scr_pkg::OFF_W-1:0]       r_rd_off, n_rd_off;
    logic [7:0]                      r_rd_byte, n_rd_byte;
    logic                            r_out_valid, n_out_valid;
    scr_pkg::t_result                r_out, n_out;

    logic                            complete;
    logic                            ignoring;
    logic                            out_free;
    logic                            wr_cond;
    logic [scr_pkg::CHUNK_SEL_W-1:0] head_seq;
    logic [8:0]                      len_sum;
    scr_pkg::t_status                chk;
    logic                            chk_commit;
    logic                            chk_set_exp;
    logic [scr_pkg::CNT_W-1:0]       exp_eff;
    scr_pkg::t_status                rd_status;
    logic                            rd_more;
    logic [scr_pkg::CHUNK_SEL_W-1:0] rd_idx;
    logic                            ram_we;
    logic [scr_pkg::ADDR_W-1:0]      ram_raddr;
    logic [7:0]                      ram_rdata;

    scr_ram #(
        .WIDTH (8),
        .DEPTH (scr_pkg::PAYLOAD_MAX)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_q_head.wr_addr),
        .i_wdata (i_q_head.data),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_m_valid  = r_out_valid;
    assign o_m_result = r_out;

    // frame checks in their fixed order
    always_comb begin
        complete = (r_exp_total != '0) && (r_rcv == r_exp_total) &&
                   (r_sticky == scr_pkg::ST_PENDING);
        ignoring = (r_sticky != scr_pkg::ST_PENDING) || complete;
        head_seq = i_q_head.seq[scr_pkg::CHUNK_SEL_W-1:0];
        len_sum  = 9'(i_q_head.len) + 9'(scr_pkg::HEADER_BYTES);
        exp_eff  = (r_exp_total == '0) ? scr_pkg::CNT_W'(i_q_head.total) : r_exp_total;
        wr_cond  = i_q_head.wr_ok && !ignoring && !r_seen[head_seq];

        chk         = scr_pkg::ST_PENDING;
        chk_commit  = 1'b0;
        chk_set_exp = 1'b0;
        if (i_q_head.size < scr_pkg::POS_W'(scr_pkg::HEADER_BYTES)) begin
            chk = scr_pkg::ST_SHORT;
        end else if (i_q_head.size > scr_pkg::POS_W'(scr_pkg::FRAME_MAX)) begin
            chk = scr_pkg::ST_LONG;
        end else if (i_q_head.ver != i_frame_version) begin
            chk = scr_pkg::ST_VERSION;
        end else if (i_q_head.total == '0) begin
            chk = scr_pkg::ST_ZERO;
        end else if (i_q_head.total > 16'(scr_pkg::MAX_CHUNKS)) begin
            chk = scr_pkg::ST_LARGE;
        end else if ((i_q_head.len > 8'(scr_pkg::CHUNK_DATA_MAX)) ||
                     (9'(i_q_head.size) != len_sum)) begin
            chk = scr_pkg::ST_LENGTH;
        end else if (i_q_head.seq >= i_q_head.total) begin
            chk = scr_pkg::ST_RANGE;
        end else if ((r_exp_total != '0) && (i_q_head.total != 16'(r_exp_total))) begin
            chk = scr_pkg::ST_TOTAL;
        end else begin
            chk_set_exp = (r_exp_total == '0);
            if (i_q_head.seq >= 16'(scr_pkg::MAX_CHUNKS)) begin
                chk = scr_pkg::ST_RANGE;
            end else if (r_seen[head_seq]) begin
                chk = scr_pkg::ST_DUP;
            end else begin
                chk_commit = 1'b1;
                chk = (scr_pkg::CNT_W'(r_rcv + scr_pkg::CNT_W'(1)) == exp_eff) ?
                      scr_pkg::ST_COMPLETE : scr_pkg::ST_PENDING;
            end
        end
    end

    // command execution and readout sequencer
    always_comb begin
        out_free  = !r_out_valid || i_m_ready;
        rd_status = (r_sticky != scr_pkg::ST_PENDING) ? r_sticky :
                    (complete ? scr_pkg::ST_COMPLETE : scr_pkg::ST_PENDING);
        rd_more   = (r_rd_chunk < r_exp_total);
        rd_idx    = r_rd_chunk[scr_pkg::CHUNK_SEL_W-1:0];
        ram_raddr = scr_pkg::ADDR_W'(scr_pkg::ADDR_W'(rd_idx) *
                    scr_pkg::ADDR_W'(scr_pkg::CHUNK_DATA_MAX) +
                    scr_pkg::ADDR_W'(r_rd_off));

        n_state     = r_state;
        n_exp_total = r_exp_total;
        n_rcv       = r_rcv;
        n_seen      = r_seen;
        n_len       = r_len;
        n_sticky    = r_sticky;
        n_rd_chunk  = r_rd_chunk;
        n_rd_off    = r_rd_off;
        n_rd_byte   = r_rd_byte;
        n_out_valid = i_m_ready ? 1'b0 : r_out_valid;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        ram_we      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_q_head.op)
                        scr_pkg::OP_BYTE: begin
                            o_q_pop = 1'b1;
                            ram_we  = wr_cond;
                        end
                        scr_pkg::OP_END: begin
                            if (out_free) begin
                                o_q_pop      = 1'b1;
                                ram_we       = wr_cond;
                                n_out_valid  = 1'b1;
                                n_out        = '0;
                                n_out.status = ignoring ? scr_pkg::ST_IGNORED : chk;
                                if (!ignoring) begin
                                    if (chk_set_exp) begin
                                        n_exp_total = scr_pkg::CNT_W'(i_q_head.total);
                                    end
                                    if (chk_commit) begin
                                        n_seen[head_seq] = 1'b1;
                                        n_len[head_seq]  = i_q_head.len;
                                        n_rcv = scr_pkg::CNT_W'(r_rcv + scr_pkg::CNT_W'(1));
                                    end
                                    if (chk >= scr_pkg::ST_SHORT) begin
                                        n_sticky = chk;
                                    end
                                end
                            end
                        end
                        scr_pkg::OP_READ: begin
                            if (out_free) begin
                                o_q_pop = 1'b1;
                                if (complete) begin
                                    n_state = S_SKIP_A;
                                end else begin
                                    n_out_valid  = 1'b1;
                                    n_out        = '0;
                                    n_out.status = rd_status;
                                end
                            end
                        end
                        scr_pkg::OP_CLEAR: begin
                            o_q_pop     = 1'b1;
                            n_exp_total = '0;
                            n_rcv       = '0;
                            n_seen      = '0;
                            n_sticky    = scr_pkg::ST_PENDING;
                            n_rd_chunk  = '0;
                            n_rd_off    = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SKIP_A, S_SKIP_B: begin
                // one spent or empty chunk skipped per cycle
                if (rd_more && (r_rd_off >= r_len[rd_idx])) begin
                    n_rd_chunk = scr_pkg::CNT_W'(r_rd_chunk + scr_pkg::CNT_W'(1));
                    n_rd_off   = '0;
                end else if (r_state == S_SKIP_A) begin
                    if (rd_more) begin
                        n_state = S_FETCH;
                    end else begin
                        n_state      = S_IDLE;
                        n_out_valid  = 1'b1;
                        n_out        = '0;
                        n_out.status = rd_status;
                    end
                end else begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out.status = rd_status;
                    n_out.pbyte  = r_rd_byte;
                    n_out.pvalid = 1'b1;
                    n_out.plast  = !rd_more;
                end
            end
            S_FETCH: begin
                n_rd_byte = ram_rdata;
                n_rd_off  = scr_pkg::OFF_W'(r_rd_off + scr_pkg::OFF_W'(1));
                n_state   = S_SKIP_B;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_len     <= n_len;
        r_rd_byte <= n_rd_byte;
        r_out     <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_exp_total <= '0;
            r_rcv       <= '0;
            r_seen      <= '0;
            r_sticky    <= scr_pkg::ST_PENDING;
            r_rd_chunk  <= '0;
            r_rd_off    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_exp_total <= n_exp_total;
            r_rcv       <= n_rcv;
            r_seen      <= n_seen;
            r_sticky    <= n_sticky;
            r_rd_chunk  <= n_rd_chunk;
            r_rd_off    <= n_rd_off;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> hdl/sequenced_chunk_reassembler_core.sv
// sequenced chunk reassembler, top level: stream ports, version register,
// front end, command queue and back end; depends on scr_pkg and all scr_ modules
//
// Frames come in one byte per transaction (tuser = 0): version, sequence (two
// bytes, high first), total (two bytes, high first), data length, then data;
// tlast marks the frame's final byte, which returns one status transaction.
// tuser = 1 reads the next reassembled payload byte (one transaction back),
// tuser = 2 clears the reassembly and any partial frame (nothing back), and
// tuser = 3 is dropped. The first error is sticky until a clear. Timing: a
// front end takes one item per cycle into a four-entry command queue while
// that queue has room; the back end, while idle, retires a frame byte or a
// clear when it heads the queue and a frame end once the output register is
// free. A read of an incomplete set answers with the status alone; a read
// of a complete set runs the readout sequencer through its skip, fetch and
// second skip states (first skip only, once the payload is exhausted), which
// steps over spent or empty chunks one per cycle and reads the chunk store
// through its registered read port, and it needs no clearing pass after reset.
module sequenced_chunk_reassembler_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0] i_s_axis_tuser,   // [1:0] func
    input  logic       i_s_axis_tlast,   // frame_last
    // result stream
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] payload_byte
    output logic [4:0] o_m_axis_tuser,   // [3:0] status, [4] payload_valid
    output logic       o_m_axis_tlast,   // payload_last
    // frame_version register write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    // expected version byte, reset value 1
    logic [7:0]       r_frame_version;

    logic             push;
    scr_pkg::t_cmd    push_cmd;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    scr_pkg::t_cmd    q_head;
    scr_pkg::t_result result;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_version <= 8'd1;
        end else if (i_cfg_valid) begin
            r_frame_version <= i_cfg_data;
        end
    end

    // front end: frame position, header capture, command build
    scr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_func   (i_s_axis_tuser),
        .i_data   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .i_q_full (q_full),
        .o_ready  (o_s_axis_tready),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // decouples transaction intake from command execution
    scr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // back end: checks, sticky error, chunk store, readout, output register
    scr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frame_version (r_frame_version),
        .i_q_empty       (q_empty),
        .i_q_head        (q_head),
        .o_q_pop         (q_pop),
        .i_m_ready       (i_m_axis_tready),
        .o_m_valid       (o_m_axis_tvalid),
        .o_m_result      (result)
    );

    // result fields onto the stream
    assign o_m_axis_tdata = result.pbyte;
    assign o_m_axis_tuser = {result.pvalid, result.status};
    assign o_m_axis_tlast = result.plast;

endmodule

>>> hdl/scr_checker.sv
// port-level checks of the sequenced chunk reassembler, bound to the top level
// depends on scr_pkg and sequenced_chunk_reassembler_core_macros.svh
`include "sequenced_chunk_reassembler_core_macros.svh"

module scr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic [4:0] o_m_axis_tuser,
    input logic       o_m_axis_tlast
);

    // a stalled result holds
    `SCR_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))

    // no payload byte means zero data and no last flag
    `SCR_ASSERT(a_no_payload_zero, (o_m_axis_tvalid && !o_m_axis_tuser[4] |-> o_m_axis_tdata == 8'd0 && !o_m_axis_tlast))

    // payload bytes only come out of a complete set
    `SCR_ASSERT(a_payload_complete, (o_m_axis_tvalid && o_m_axis_tuser[4] |-> o_m_axis_tuser[3:0] == scr_pkg::ST_COMPLETE))

    // status codes stay within the defined range
    `SCR_ASSERT(a_status_range, (o_m_axis_tvalid |-> o_m_axis_tuser[3:0] <= scr_pkg::ST_DUP))

endmodule

bind sequenced_chunk_reassembler_core scr_checker u_scr_checker (.*);
